FILE: design/dbs_pkg.sv
`default_nettype none
package dbs_pkg;

	// Field widths
	localparam int unsigned ACC_W   = 16;
	localparam int unsigned BAND_W  = 15;
	localparam int unsigned STEP_W  = 5;
	localparam int unsigned LIMIT_W = 8;
	localparam int unsigned ANGLE_W = 8;
	localparam int unsigned COUNT_W = 9;
	localparam int unsigned CMP_W   = ACC_W + 2;
	localparam int unsigned IDX_W   = 3;
	localparam int unsigned DATA_W  = 16;

	// Register indexes
	localparam logic [IDX_W-1:0] REG_TARGET_X = 3'd0;
	localparam logic [IDX_W-1:0] REG_TARGET_Y = 3'd1;
	localparam logic [IDX_W-1:0] REG_BAND_X   = 3'd2;
	localparam logic [IDX_W-1:0] REG_BAND_Y   = 3'd3;
	localparam logic [IDX_W-1:0] REG_STEP_X   = 3'd4;
	localparam logic [IDX_W-1:0] REG_STEP_Y   = 3'd5;
	localparam logic [IDX_W-1:0] REG_HOLDOFF  = 3'd6;

	// Register reset values
	localparam logic signed [ACC_W-1:0] TARGET_RST = 16'sd0;
	localparam logic [BAND_W-1:0]       BAND_RST   = 15'd300;
	localparam logic [STEP_W-1:0]       STEP_RST   = 5'd5;
	localparam logic [LIMIT_W-1:0]      LIMIT_RST  = 8'd10;

	// Angle stops
	localparam logic [ANGLE_W-1:0] ANGLE_START = 8'd90;
	localparam logic [ANGLE_W-1:0] ANGLE_UPPER = 8'd150;
	localparam logic [ANGLE_W-1:0] ANGLE_LOWER = 8'd20;

	typedef struct packed {
		logic signed [ACC_W-1:0] target;
		logic [BAND_W-1:0]       band;
		logic [STEP_W-1:0]       step;
		logic [LIMIT_W-1:0]      limit;
	} dbs_axis_cfg_t;

	typedef struct packed {
		logic [ANGLE_W-1:0] angle;
		logic               moved;
	} dbs_axis_res_t;

	typedef struct packed {
		logic [ANGLE_W-1:0] angle_x;
		logic [ANGLE_W-1:0] angle_y;
		logic               moved_x;
		logic               moved_y;
	} dbs_result_t;

endpackage
`default_nettype wire

FILE: design/dbs_lane.sv
`default_nettype none
module dbs_lane import dbs_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    accept,
	input  wire logic signed [ACC_W-1:0] acc,
	input  wire dbs_axis_cfg_t           cfg,
	output dbs_axis_res_t                res
);

	logic [ANGLE_W-1:0] angle_q;
	logic               hold_q;
	logic [COUNT_W-1:0] count_q;

	logic [ANGLE_W-1:0] angle_d;
	logic               hold_d;
	logic [COUNT_W-1:0] count_d;
	logic               moved;

	logic signed [CMP_W-1:0] acc_e;
	logic signed [CMP_W-1:0] lo_bound;
	logic signed [CMP_W-1:0] hi_bound;
	logic                    below;
	logic                    above;
	logic [ANGLE_W:0]        raised;

	// Form the dead band bounds at full precision
	always_comb begin
		acc_e    = CMP_W'(acc);
		lo_bound = CMP_W'(cfg.target) - $signed({3'b000, cfg.band});
		hi_bound = CMP_W'(cfg.target) + $signed({3'b000, cfg.band});
		below    = acc_e < lo_bound;
		above    = acc_e > hi_bound;
		raised   = {1'b0, angle_q} + {4'b0000, cfg.step};
	end

	// Step the angle, or advance or clear the hold-off count
	always_comb begin
		angle_d = angle_q;
		hold_d  = hold_q;
		count_d = count_q;
		moved   = 1'b0;
		if (!hold_q) begin
			if (below) begin
				if (angle_q < ANGLE_UPPER) begin
					angle_d = raised[ANGLE_W-1:0];
				end
			end else if (above) begin
				if (angle_q > ANGLE_LOWER) begin
					if ({3'b000, cfg.step} > angle_q) begin
						angle_d = '0;
					end else begin
						angle_d = angle_q - {3'b000, cfg.step};
					end
				end
			end
			if (angle_d != angle_q) begin
				moved  = 1'b1;
				hold_d = 1'b1;
			end
		end else if (count_q > {1'b0, cfg.limit}) begin
			count_d = '0;
			hold_d  = 1'b0;
		end else begin
			count_d = count_q + COUNT_W'(1);
		end
	end

	// Commit the axis state on each accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q <= ANGLE_START;
			hold_q  <= 1'b0;
			count_q <= '0;
		end else if (accept) begin
			angle_q <= angle_d;
			hold_q  <= hold_d;
			count_q <= count_d;
		end
	end

	assign res.angle = angle_d;
	assign res.moved = moved;

endmodule
`default_nettype wire

FILE: design/dbs_merge.sv
`default_nettype none
module dbs_merge import dbs_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          accept,
	input  wire dbs_axis_res_t lane_x,
	input  wire dbs_axis_res_t lane_y,
	input  wire logic          out_stall,
	output logic               out_valid,
	output logic               full,
	output dbs_result_t        result
);

	dbs_result_t merged;
	dbs_result_t out_q;
	dbs_result_t skid_q;
	logic        out_valid_q;
	logic        skid_full_q;
	logic        out_take;

	// Combine the lane results into one request
	always_comb begin
		merged.angle_x = lane_x.angle;
		merged.angle_y = lane_y.angle;
		merged.moved_x = lane_x.moved;
		merged.moved_y = lane_y.moved;
	end

	assign out_take = out_valid_q && !out_stall;

	// Hold valid flags of the output and skid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_full_q <= 1'b0;
		end else if (skid_full_q) begin
			if (out_take) begin
				skid_full_q <= 1'b0;
			end
		end else if (accept) begin
			if (out_valid_q && !out_take) begin
				skid_full_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	// Move payload into the output register or park it in the skid
	always_ff @(posedge clk) begin
		if (skid_full_q) begin
			if (out_take) begin
				out_q <= skid_q;
			end
		end else if (accept) begin
			if (out_valid_q && !out_take) begin
				skid_q <= merged;
			end else begin
				out_q <= merged;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign full      = skid_full_q;
	assign result    = out_q;

endmodule
`default_nettype wire

FILE: design/two_axis_deadband_servo_stepper.sv
// Channel | Direction | Handshake             | Payload
// in      | input     | in_valid / in_stall   | accel_x, accel_y
// out     | output    | out_valid / out_stall | angle_x, angle_y, moved_x, moved_y
// cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One request per clock while in_stall is low; each accepted result is registered in the output register or skid.
// Both axis lanes update their angle and hold-off state in the accepting cycle.
// A two-entry output register and skid let a request in while a result waits;
// in_stall rises only when both entries hold results.
// arst_n resets angles to 90 and the hold-off, config and valid-flag registers.
// cfg_ready is always high; writes to an unknown index are dropped.
`default_nettype none
module two_axis_deadband_servo_stepper import dbs_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic signed [ACC_W-1:0]  accel_x,
	input  wire logic signed [ACC_W-1:0]  accel_y,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic [ANGLE_W-1:0]            angle_x,
	output logic [ANGLE_W-1:0]            angle_y,
	output logic                          moved_x,
	output logic                          moved_y,
	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire logic [IDX_W-1:0]         cfg_index,
	input  wire logic [DATA_W-1:0]        cfg_data
);

	logic signed [ACC_W-1:0] target_x_q;
	logic signed [ACC_W-1:0] target_y_q;
	logic [BAND_W-1:0]       band_x_q;
	logic [BAND_W-1:0]       band_y_q;
	logic [STEP_W-1:0]       step_x_q;
	logic [STEP_W-1:0]       step_y_q;
	logic [LIMIT_W-1:0]      limit_q;

	dbs_axis_cfg_t cfg_x;
	dbs_axis_cfg_t cfg_y;
	dbs_axis_res_t res_x;
	dbs_axis_res_t res_y;
	dbs_result_t   result;
	logic          accept;
	logic          full;

	assign cfg_ready = 1'b1;
	assign in_stall  = full;
	assign accept    = in_valid && !full;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_x_q <= TARGET_RST;
			target_y_q <= TARGET_RST;
			band_x_q   <= BAND_RST;
			band_y_q   <= BAND_RST;
			step_x_q   <= STEP_RST;
			step_y_q   <= STEP_RST;
			limit_q    <= LIMIT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_TARGET_X: target_x_q <= $signed(cfg_data);
				REG_TARGET_Y: target_y_q <= $signed(cfg_data);
				REG_BAND_X:   band_x_q   <= cfg_data[BAND_W-1:0];
				REG_BAND_Y:   band_y_q   <= cfg_data[BAND_W-1:0];
				REG_STEP_X:   step_x_q   <= cfg_data[STEP_W-1:0];
				REG_STEP_Y:   step_y_q   <= cfg_data[STEP_W-1:0];
				REG_HOLDOFF:  limit_q    <= cfg_data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// Bundle per-axis settings
	always_comb begin
		cfg_x.target = target_x_q;
		cfg_x.band   = band_x_q;
		cfg_x.step   = step_x_q;
		cfg_x.limit  = limit_q;
		cfg_y.target = target_y_q;
		cfg_y.band   = band_y_q;
		cfg_y.step   = step_y_q;
		cfg_y.limit  = limit_q;
	end

	dbs_lane u_lane_x (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.acc    (accel_x),
		.cfg    (cfg_x),
		.res    (res_x)
	);

	dbs_lane u_lane_y (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.acc    (accel_y),
		.cfg    (cfg_y),
		.res    (res_y)
	);

	dbs_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.lane_x    (res_x),
		.lane_y    (res_y),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.full      (full),
		.result    (result)
	);

	assign angle_x = result.angle_x;
	assign angle_y = result.angle_y;
	assign moved_x = result.moved_x;
	assign moved_y = result.moved_y;

endmodule
`default_nettype wire

FILE: design/dbs_checker.sv
`default_nettype none
module dbs_checker import dbs_pkg::*; (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_stall,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire logic [ANGLE_W-1:0] angle_x,
	input wire logic [ANGLE_W-1:0] angle_y,
	input wire logic               moved_x,
	input wire logic               moved_y,
	input wire logic               cfg_ready
);

	// A stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(angle_x) && $stable(angle_y)
			&& $stable(moved_x) && $stable(moved_y))
		else $error("result payload changed while stalled");

	// Input stalls only with a result waiting
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with empty output");

	// Angles stay within servo range
	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (angle_x <= 8'd180) && (angle_y <= 8'd180))
		else $error("angle out of range");

	// Configuration port never back-pressures
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port not ready");

endmodule

bind two_axis_deadband_servo_stepper dbs_checker u_dbs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.angle_x   (angle_x),
	.angle_y   (angle_y),
	.moved_x   (moved_x),
	.moved_y   (moved_y),
	.cfg_ready (cfg_ready)
);
`default_nettype wire
